// ===== hw/rtl/fpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types, constants and CRC helper for the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned LEN_W     = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef enum logic [1:0] {
    ST_RX,
    ST_READ,
    ST_OUT
  } fpr_state_e;

  // one bit of the reflected CRC-16-CCITT
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    logic [15:0] r;
    r = {1'b0, c[15:1]};
    if (c[0]) begin
      r = r ^ CRC_POLY;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fpr_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_rx_if
// Received serial byte channel, one word per byte.
// ----------------------------------------------------------------------------
interface fpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

// ===== hw/rtl/fpr_pkt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkt_if
// Payload readout channel, one word per payload byte.
// ----------------------------------------------------------------------------
interface fpr_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_id;
  logic [7:0] comp_id;
  logic [5:0] payload_length;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       has_data;
  logic       last;

  modport source (output valid, output msg_id, output comp_id,
                  output payload_length, output byte_index, output payload_byte,
                  output has_data, output last, input ready);
  modport sink   (input valid, input msg_id, input comp_id,
                  input payload_length, input byte_index, input payload_byte,
                  input has_data, input last, output ready);
endinterface

// ===== hw/rtl/fpr_crc_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_crc_serial
// Bit-serial CRC-16-CCITT (reflected): first bit on load, the rest while busy.
// ----------------------------------------------------------------------------
module fpr_crc_serial
  import fpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] init_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o,
  output logic        busy_o
);

  logic [15:0] crc_q, crc_d;
  logic [2:0]  cnt_q, cnt_d;

  assign busy_o = (cnt_q != 3'd0);
  assign crc_o  = crc_q;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (start_i) begin
      crc_d = crc_step(init_i ^ {8'h00, data_i});
      cnt_d = 3'd7;
    end else if (busy_o) begin
      crc_d = crc_step(crc_q);
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      cnt_q <= 3'd0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/fpr_payload_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_payload_ram
// Payload store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpr_payload_ram #(
  parameter int unsigned DEPTH = 60,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/framed_packet_receiver_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16
// Start-marker deframer with CRC-16-CCITT check and payload readout.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received byte per word. While hunting, a word equal to
//   the start marker opens a frame: length, message id, component id,
//   payload, then CRC low and high. Frames whose length overflows the buffer
//   and frames with a bad CRC byte are dropped without output.
//   pkt_o gives one word per payload byte of a good frame, or one word with
//   has_data clear for an empty payload; last marks the final word.
//   rx_i is not ready while the bit-serial CRC unit works on a header or
//   payload byte, so the next byte waits for it; other bytes do not stall.
//   Readout: per word a RAM read state, then an output state, from the
//   cycle after the second CRC byte; an empty payload's single word needs
//   no RAM read and is offered then. rx_i is not ready during readout.
//   A stalled pkt_o holds its word and keeps rx_i stalled.
//   Reset: hunting, start marker 0, CRC at 0xFFFF; no clearing pass.
//   cfg_we_i writes the start marker; write only while idle.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16
  import fpr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  fpr_rx_if.sink     rx_i,
  fpr_pkt_if.source  pkt_o
);

  localparam int unsigned DEPTH = BUFFER_BYTES - HDR_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  fpr_state_e state_q, state_d;

  logic [7:0]       marker_q;
  logic             in_frame_q, in_frame_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       msg_q, msg_d;
  logic [7:0]       comp_q, comp_d;
  logic             has_data_q, has_data_d;
  logic [LEN_W-1:0] rd_idx_q, rd_idx_d;

  logic        rx_acc, pkt_acc, rd_start, last;
  logic        crc_start, crc_busy, ram_we, ram_re;
  logic [15:0] crc_init, crc_val;
  logic [POS_W-1:0] pay_end, waddr_full;

  assign rx_acc     = rx_i.valid & rx_i.ready;
  assign pkt_acc    = pkt_o.valid & pkt_o.ready;
  assign pay_end    = POS_W'(len_q) + POS_W'(3);
  assign waddr_full = pos_q - POS_W'(3);
  assign last       = !has_data_q ||
                      ((POS_W'(rd_idx_q) + POS_W'(1)) == POS_W'(len_q));

  fpr_crc_serial u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(crc_start),
    .init_i (crc_init),
    .data_i (rx_i.rx_data),
    .crc_o  (crc_val),
    .busy_o (crc_busy)
  );

  logic [7:0] ram_rdata;

  fpr_payload_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr_full[AW-1:0]),
    .wdata_i(rx_i.rx_data),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // frame parsing
  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    msg_d      = msg_q;
    comp_d     = comp_q;
    has_data_d = has_data_q;
    rd_idx_d   = rd_idx_q;
    crc_start  = 1'b0;
    crc_init   = crc_val;
    ram_we     = 1'b0;
    rd_start   = 1'b0;
    if (rx_acc) begin
      if (!in_frame_q) begin
        if (rx_i.rx_data == marker_q) begin
          in_frame_d = 1'b1;
          pos_d      = '0;
        end
      end else begin
        priority if (pos_q == POS_W'(0)) begin
          if ((9'(rx_i.rx_data) + 9'(HDR_BYTES)) > 9'(BUFFER_BYTES)) begin
            in_frame_d = 1'b0;
            pos_d      = '0;
          end else begin
            len_d     = rx_i.rx_data[LEN_W-1:0];
            crc_start = 1'b1;
            crc_init  = CRC_INIT;
            pos_d     = pos_q + POS_W'(1);
          end
        end else if (pos_q == POS_W'(1)) begin
          msg_d     = rx_i.rx_data;
          crc_start = 1'b1;
          pos_d     = pos_q + POS_W'(1);
        end else if (pos_q == POS_W'(2)) begin
          comp_d    = rx_i.rx_data;
          crc_start = 1'b1;
          pos_d     = pos_q + POS_W'(1);
        end else if (pos_q < pay_end) begin
          ram_we    = 1'b1;
          crc_start = 1'b1;
          pos_d     = pos_q + POS_W'(1);
        end else if (pos_q == pay_end) begin
          if (rx_i.rx_data != crc_val[7:0]) begin
            in_frame_d = 1'b0;
            pos_d      = '0;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end else begin
          in_frame_d = 1'b0;
          pos_d      = '0;
          if (rx_i.rx_data == crc_val[15:8]) begin
            rd_start   = 1'b1;
            has_data_d = (len_q != '0);
            rd_idx_d   = '0;
          end
        end
      end
    end
    if (pkt_acc) begin
      rd_idx_d = rd_idx_q + LEN_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RX: begin
        if (rd_start) begin
          state_d = has_data_d ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (pkt_acc) begin
          state_d = last ? ST_RX : ST_READ;
        end
      end
      default: state_d = ST_RX;
    endcase
  end

  // state outputs
  always_comb begin
    rx_i.ready  = 1'b0;
    ram_re      = 1'b0;
    pkt_o.valid = 1'b0;
    unique case (state_q)
      ST_RX:   rx_i.ready  = !crc_busy;
      ST_READ: ram_re      = 1'b1;
      ST_OUT:  pkt_o.valid = 1'b1;
      default: rx_i.ready  = 1'b0;
    endcase
  end

  assign pkt_o.msg_id         = msg_q;
  assign pkt_o.comp_id        = comp_q;
  assign pkt_o.payload_length = len_q;
  assign pkt_o.byte_index     = rd_idx_q;
  assign pkt_o.payload_byte   = has_data_q ? ram_rdata : 8'h00;
  assign pkt_o.has_data       = has_data_q;
  assign pkt_o.last           = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RX;
      marker_q   <= 8'h00;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      msg_q      <= 8'h00;
      comp_q     <= 8'h00;
      has_data_q <= 1'b0;
      rd_idx_q   <= '0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      msg_q      <= msg_d;
      comp_q     <= comp_d;
      has_data_q <= has_data_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

endmodule
